// ===== rtl/reuse_distance_replacement_core_macros.svh =====
// Assertion macros for the reuse distance replacement core.
// Used by the checker; needs nothing else.
`ifndef REUSE_DISTANCE_REPLACEMENT_CORE_MACROS_SVH
`define REUSE_DISTANCE_REPLACEMENT_CORE_MACROS_SVH

// Check an implication into the next cycle, masked during reset.
`define RDR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// Check an implication into the next cycle, active during reset too.
`define RDR_ASSERT_NEXT_ALWAYS(label, clk, pre, post, msg) \
    label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/rdr_pkg.sv =====
// Shared types, constants and helpers of the reuse distance replacement core.
// No dependencies.
package rdr_pkg;

    localparam int SETS            = 64;
    localparam int SET_W           = $clog2(SETS);
    localparam int WAYS            = 16;
    localparam int WAY_W           = $clog2(WAYS);
    localparam int AGE_MAX         = 31;
    localparam int AGE_W           = $clog2(AGE_MAX + 1);
    localparam int UPDATE_INTERVAL = 32;
    localparam int CNT_W           = $clog2(UPDATE_INTERVAL);
    localparam int ACC_W           = 10;
    localparam int REUSE_SHIFT     = 4;
    localparam int REUSE_W         = 6;
    localparam int DEFAULT_REUSE   = 8;
    localparam int QDEPTH          = 2;

    typedef enum logic [1:0] {
        OP_HIT    = 2'd0,
        OP_MISS   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic {
        BS_IDLE,
        BS_EXEC
    } t_bstate;

    // Classified command between front and back.
    typedef struct packed {
        t_op              op;
        logic [SET_W-1:0] set;
        logic [WAY_W-1:0] way;
        logic             way_ok;
    } t_cmd;

    // Queue handshake toward the back.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    // Metadata of one set, kept as one memory row.
    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0]             hit;
        logic [WAYS-1:0][AGE_W-1:0]  age;
        logic [WAYS-1:0][WAY_W-1:0]  rank;
        logic [ACC_W-1:0]            acc;
        logic [CNT_W-1:0]            cnt;
        logic [REUSE_W-1:0]          reuse;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    // Row contents after reset.
    function automatic t_row reset_row();
        t_row r;
        r       = '0;
        r.reuse = REUSE_W'(DEFAULT_REUSE);
        for (int k = 0; k < WAYS; k++) begin
            r.rank[k] = WAY_W'(k);
        end
        return r;
    endfunction

endpackage

// ===== rtl/rdr_if.sv =====
// Valid/ready channel interfaces of the reuse distance replacement core.
// No dependencies.
interface rdr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [5:0] set_index;
    logic [3:0] way_index;

    modport source (output valid, output opcode, output set_index, output way_index,
                    input ready);
    modport sink   (input valid, input opcode, input set_index, input way_index,
                    output ready);
endinterface

interface rdr_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] victim_way;
    logic       evicted_valid;

    modport source (output valid, output victim_way, output evicted_valid, input ready);
    modport sink   (input valid, input victim_way, input evicted_valid, output ready);
endinterface

// ===== rtl/rdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rdr_front.sv =====
// Front end: accepts request beats, classifies them and queues commands.
// Depends on rdr_pkg and rdr_if.
module rdr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rdr_req_if.sink       i_req,
    input  logic          i_pop,
    output rdr_pkg::t_qhead o_head
);
    import rdr_pkg::*;

    t_cmd             r_q [QDEPTH];
    logic             r_wptr, n_wptr;
    logic             r_rptr, n_rptr;
    logic [1:0]       r_cnt, n_cnt;
    t_cmd             w_cmd;
    logic             w_push;
    logic             w_pop;

    // Classify the incoming beat.
    always_comb begin
        w_cmd.op     = t_op'(i_req.opcode);
        w_cmd.set    = i_req.set_index[SET_W-1:0];
        w_cmd.way    = i_req.way_index;
        w_cmd.way_ok = (int'(i_req.way_index) < WAYS);
    end

    assign i_req.ready = (r_cnt != 2'(QDEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_pop && (r_cnt != 2'd0);

    // Advance pointers and fill count.
    always_comb begin
        n_wptr = w_push ? ~r_wptr : r_wptr;
        n_rptr = w_pop  ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Hold queued commands.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rptr];
endmodule

// ===== rtl/rdr_back.sv =====
// Back end: read-modify-write of one set row per command, result register.
// Depends on rdr_pkg, rdr_if and rdr_ram.
module rdr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rdr_pkg::t_qhead i_head,
    output logic            o_pop,
    rdr_rsp_if.source       o_rsp
);
    import rdr_pkg::*;

    localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(AGE_MAX);

    t_bstate          r_state, n_state;
    t_cmd             r_cmd;
    logic [SETS-1:0]  r_row_init;
    logic             r_out_valid, n_out_valid;
    logic [WAY_W-1:0] r_victim;
    logic             r_evict;

    logic             w_start;
    logic             w_exec;
    t_row             w_ram_q;
    t_row             w_cur;
    t_row             w_nxt;
    logic [WAY_W-1:0] w_victim;
    logic             w_evict;

    // Move a way to most recent, shifting the more recent ones down.
    function automatic logic [WAYS-1:0][WAY_W-1:0] make_mru(
        input logic [WAYS-1:0][WAY_W-1:0] rk,
        input logic [WAY_W-1:0]           w
    );
        logic [WAYS-1:0][WAY_W-1:0] res;
        logic [WAY_W-1:0]           old;
        old = rk[w];
        res = rk;
        for (int k = 0; k < WAYS; k++) begin
            if (rk[k] < old) begin
                res[k] = rk[k] + 1'b1;
            end
        end
        res[w] = '0;
        return res;
    endfunction

    assign w_start = (r_state == BS_IDLE) && i_head.valid && (!r_out_valid || o_rsp.ready);
    assign w_exec  = (r_state == BS_EXEC);
    assign o_pop   = w_start;

    rdr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_exec),
        .i_waddr (r_cmd.set),
        .i_wdata (w_nxt),
        .i_re    (w_start),
        .i_raddr (i_head.cmd.set),
        .o_rdata (w_ram_q)
    );

    // Rows never written read as their reset contents.
    assign w_cur = r_row_init[r_cmd.set] ? w_ram_q : reset_row();

    // Update the row and pick the victim.
    always_comb begin
        logic [WAYS-1:0][AGE_W-1:0] aged;
        logic [WAYS-1:0][1:0]       score;
        logic [WAYS-1:0]            cand;
        logic [WAYS-1:0]            win;
        logic [3:0]                 has_s;
        logic [1:0]                 min_s;
        logic                       inv_found;
        logic [WAY_W-1:0]           inv_way;
        logic [ACC_W-1:0]           acc_sum;
        logic [CNT_W:0]             cnt_sum;
        logic [REUSE_W-1:0]         est;

        w_nxt     = w_cur;
        w_victim  = r_cmd.way;
        w_evict   = 1'b0;
        aged      = w_cur.age;
        score     = '0;
        cand      = '0;
        win       = '0;
        has_s     = '0;
        min_s     = 2'd3;
        inv_found = 1'b0;
        inv_way   = '0;
        acc_sum   = '0;
        cnt_sum   = '0;
        est       = '0;

        unique case (r_cmd.op)
            OP_HIT: begin
                if (r_cmd.way_ok && w_cur.valid[r_cmd.way]) begin
                    acc_sum = w_cur.acc + ACC_W'(w_cur.age[r_cmd.way]);
                    cnt_sum = {1'b0, w_cur.cnt} + 1'b1;
                    if (int'(cnt_sum) >= UPDATE_INTERVAL) begin
                        est         = REUSE_W'(acc_sum >> REUSE_SHIFT);
                        w_nxt.reuse = (est == '0) ? REUSE_W'(1) : est;
                        w_nxt.acc   = '0;
                        w_nxt.cnt   = '0;
                    end else begin
                        w_nxt.acc = acc_sum;
                        w_nxt.cnt = cnt_sum[CNT_W-1:0];
                    end
                    w_nxt.hit[r_cmd.way] = 1'b1;
                    w_nxt.age[r_cmd.way] = '0;
                    w_nxt.rank           = make_mru(w_cur.rank, r_cmd.way);
                end
            end
            OP_MISS: begin
                // Age every valid line, saturating.
                for (int k = 0; k < WAYS; k++) begin
                    if (w_cur.valid[k] && w_cur.age[k] != AGE_TOP) begin
                        aged[k] = w_cur.age[k] + 1'b1;
                    end
                end
                // Lowest-numbered invalid way.
                for (int k = WAYS - 1; k >= 0; k--) begin
                    if (!w_cur.valid[k]) begin
                        inv_found = 1'b1;
                        inv_way   = WAY_W'(k);
                    end
                end
                // Lowest score, then least recent.
                for (int k = 0; k < WAYS; k++) begin
                    score[k] = {({1'b0, aged[k]} <= w_cur.reuse), w_cur.hit[k]};
                    has_s[score[k]] = 1'b1;
                end
                priority if (has_s[0]) min_s = 2'd0;
                else if (has_s[1])     min_s = 2'd1;
                else if (has_s[2])     min_s = 2'd2;
                else                   min_s = 2'd3;
                for (int k = 0; k < WAYS; k++) begin
                    cand[k] = (score[k] == min_s);
                end
                for (int k = 0; k < WAYS; k++) begin
                    win[k] = cand[k];
                    for (int j = 0; j < WAYS; j++) begin
                        if (cand[j] && w_cur.rank[j] > w_cur.rank[k]) begin
                            win[k] = 1'b0;
                        end
                    end
                end
                if (inv_found) begin
                    w_victim = inv_way;
                end else begin
                    w_victim = '0;
                    for (int k = 0; k < WAYS; k++) begin
                        w_victim = w_victim | (win[k] ? WAY_W'(k) : '0);
                    end
                    w_evict = 1'b1;
                end
                w_nxt.age             = aged;
                w_nxt.valid[w_victim] = 1'b1;
                w_nxt.age[w_victim]   = '0;
                w_nxt.hit[w_victim]   = 1'b0;
                w_nxt.rank            = make_mru(w_cur.rank, w_victim);
            end
            OP_REMOVE: begin
                if (r_cmd.way_ok) begin
                    w_nxt.valid[r_cmd.way] = 1'b0;
                end
            end
            OP_NONE: begin
                w_nxt = w_cur;
            end
            default: begin
                w_nxt = w_cur;
            end
        endcase
    end

    // Next state and result valid.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        unique case (r_state)
            BS_IDLE: begin
                if (r_out_valid && o_rsp.ready) begin
                    n_out_valid = 1'b0;
                end
                if (w_start) begin
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                n_out_valid = 1'b1;
                n_state     = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
            r_row_init  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_exec) begin
                r_row_init[r_cmd.set] <= 1'b1;
            end
        end
    end

    // Capture command on pop and result on execute.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cmd <= i_head.cmd;
        end
        if (w_exec) begin
            r_victim <= w_victim;
            r_evict  <= w_evict;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.victim_way    = r_victim;
    assign o_rsp.evicted_valid = r_evict;
endmodule

// ===== rtl/reuse_distance_replacement_core.sv =====
// Reuse distance replacement core: one result per event, in order.
// Path: an accepted beat is queued, its set row is read from the metadata RAM, and
// the result is registered. Each event does a read-modify-write of its set row through
// the single-port-pair metadata RAM, and no new event starts until that one is done.
// Reset: synchronous; per-set row flags clear at once, so no clearing pass is needed.
// Depends on rdr_pkg, rdr_if, rdr_front and rdr_back.
module reuse_distance_replacement_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdr_req_if.sink   i_req,
    rdr_rsp_if.source o_rsp
);
    import rdr_pkg::*;

    t_qhead w_head;
    logic   w_pop;

    rdr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    rdr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );
endmodule

// ===== rtl/rdr_checker.sv =====
// Port-level checks of the reuse distance replacement core, bound to the top.
// Depends on reuse_distance_replacement_core_macros.svh.
`include "reuse_distance_replacement_core_macros.svh"

module rdr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_victim_way,
    input logic       i_evicted_valid
);
    // Hold a stalled result beat.
    `RDR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")
    `RDR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_victim_way) && $stable(i_evicted_valid), "stalled result changed")
    // Drop results and open the input on reset.
    `RDR_ASSERT_NEXT_ALWAYS(a_rst_out, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")
    `RDR_ASSERT_NEXT_ALWAYS(a_rst_in, i_clk, !i_rst_n, i_in_ready, "input not ready after reset")
endmodule

bind reuse_distance_replacement_core rdr_checker u_rdr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_victim_way    (o_rsp.victim_way),
    .i_evicted_valid (o_rsp.evicted_valid)
);
